/* design/lzgd_pkg.sv */
`default_nettype none
package lzgd_pkg;

    // history window and result buffer sizes
    localparam int unsigned HIST_AW    = 16;
    localparam int unsigned DICT_AW    = 8;
    localparam int unsigned RES_DEPTH  = 16;
    localparam int unsigned RES_AW     = 4;
    localparam int unsigned MAX_PREFIX = 20;

    // stream limits
    localparam logic [23:0] OUT_LIMIT_RST = 24'd65536;
    localparam logic [22:0] WINDOW_SIZE   = 23'd65536;

    // request kinds
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;
    localparam logic [1:0] OP_START = 2'd3;

    // stream status codes
    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_LIMIT    = 3'd1;
    localparam logic [2:0] ST_CODE256  = 3'd2;
    localparam logic [2:0] ST_BAD_DIST = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    // one emitted byte into the result buffer
    typedef struct packed {
        logic              en;
        logic [RES_AW-1:0] idx;
        logic [7:0]        data;
        logic [23:0]       count;
    } lzgd_push_t;

    // state shown with every result of a request
    typedef struct packed {
        logic        active;
        logic [4:0]  res_n;
        logic        want;
        logic [2:0]  status;
        logic [23:0] count;
    } lzgd_info_t;

endpackage
`default_nettype wire

/* design/lzgd_ram.sv */
`default_nettype none
module lzgd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* design/lzgd_result_buf.sv */
`default_nettype none
module lzgd_result_buf (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lzgd_pkg::lzgd_push_t push,
    input  wire lzgd_pkg::lzgd_info_t info,
    output logic                     done,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [39:0]              m_tdata,  // out_byte, want_byte, status, out_count
    output logic                     m_tuser,  // byte_valid
    output logic                     m_tlast
);

    logic [7:0]  byte_mem  [lzgd_pkg::RES_DEPTH];
    logic [23:0] count_mem [lzgd_pkg::RES_DEPTH];
    logic [4:0]  rd_reg, rd_next;
    logic [4:0]  total;
    logic        has_byte;
    logic [7:0]  sel_byte;
    logic [23:0] sel_count;

    // store emitted bytes of the current request
    always_ff @(posedge aclk) begin
        if (push.en) begin
            byte_mem[push.idx]  <= push.data;
            count_mem[push.idx] <= push.count;
        end
    end

    // result selection
    always_comb begin
        has_byte  = (info.res_n != 5'd0);
        total     = has_byte ? info.res_n : 5'd1;
        sel_byte  = has_byte ? byte_mem[rd_reg[lzgd_pkg::RES_AW-1:0]] : 8'd0;
        sel_count = has_byte ? count_mem[rd_reg[lzgd_pkg::RES_AW-1:0]] : info.count;
        m_tvalid  = info.active;
        m_tlast   = (rd_reg + 5'd1 == total);
        m_tuser   = has_byte;
        m_tdata   = {4'd0, sel_count, info.status, info.want, sel_byte};
        done      = m_tvalid && m_tready && m_tlast;
        rd_next   = rd_reg;
        if (done) begin
            rd_next = 5'd0;
        end else if (m_tvalid && m_tready) begin
            rd_next = rd_reg + 5'd1;
        end
    end

    // read pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= 5'd0;
        end else begin
            rd_reg <= rd_next;
        end
    end

endmodule
`default_nettype wire

/* design/lz_gamma_dictionary_decoder.sv */
`default_nettype none
// Dictionary LZ decoder with gamma codes.
// Input channel s_*: tuser is the request kind (load dictionary entry, compressed
// byte, drain pending copy, start stream); tdata carries index and data.
// Output channel m_*: one result per emitted byte, or one empty result
// (tuser low); tlast marks the final result of a request. want_byte and status
// show the state after the whole request on each of its results.
// cfg_we/cfg_wdata write the output limit; the user must do so only while the
// block is idle; the block does not enforce it. A request is taken only when
// idle. A compressed byte is parsed one bit per cycle, paused for each literal's
// dictionary read. A drain copies bytes by a history memory read, then a write,
// up to 16 bytes. Results are then sent one per cycle while the receiver is ready.
// The single history memory port pair and the bit-serial parser set the rate.
// Reset clears all stream state and sets the limit to 65536; dictionary and
// history contents stay undefined until written. If the receiver stalls, the
// results wait in the buffer and no new request is taken.
module lz_gamma_dictionary_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // index, data
    input  wire logic [1:0]  s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_byte, want_byte, status, out_count
    output logic             m_tuser,   // byte_valid
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [23:0] cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PARSE = 3'd1;
    localparam logic [2:0] S_LIT   = 3'd2;
    localparam logic [2:0] S_CPRD  = 3'd3;
    localparam logic [2:0] S_CPWR  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [23:0] limit_reg;
    logic [23:0] wc_reg, wc_next;
    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  bits_reg, bits_next;
    logic        insuf_reg, insuf_next;
    logic [21:0] prefix_reg, prefix_next;
    logic [20:0] suffix_reg, suffix_next;
    logic [4:0]  sbl_reg, sbl_next;
    logic        explen_reg, explen_next;
    logic [15:0] src_reg, src_next;
    logic [22:0] left_reg, left_next;
    logic [2:0]  status_reg, status_next;
    logic [4:0]  resn_reg, resn_next;

    logic        accept;
    logic [7:0]  in_index;
    logic [7:0]  in_data;
    logic        want;
    logic        bit_in;
    logic [20:0] suf_new;
    logic [21:0] value;
    logic [21:0] back_dist;
    logic [4:0]  n1;
    logic        emit_req;
    logic [7:0]  emit_byte;
    logic        hist_we;
    logic        dict_we;
    logic [7:0]  dict_raddr;
    logic [7:0]  dict_rdata;
    logic [7:0]  hist_rdata;
    logic        buf_done;
    lzgd_pkg::lzgd_push_t push;
    lzgd_pkg::lzgd_info_t info;

    assign in_index = s_tdata[7:0];
    assign in_data  = s_tdata[15:8];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign want     = (status_reg == lzgd_pkg::ST_RUN) && (left_reg == 23'd0)
                      && (bits_reg == 4'd0);

    // dictionary and history memories
    assign dict_we = accept && (s_tuser == lzgd_pkg::OP_LOAD);

    lzgd_ram #(.WIDTH(8), .DEPTH(256)) u_dict (
        .aclk  (aclk),
        .we    (dict_we),
        .waddr (in_index),
        .wdata (in_data),
        .raddr (dict_raddr),
        .rdata (dict_rdata)
    );

    lzgd_ram #(.WIDTH(8), .DEPTH(65536)) u_hist (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (wc_reg[lzgd_pkg::HIST_AW-1:0]),
        .wdata (emit_byte),
        .raddr (src_reg),
        .rdata (hist_rdata)
    );

    // decode control
    always_comb begin
        state_next  = state_reg;
        wc_next     = wc_reg;
        shift_next  = shift_reg;
        bits_next   = bits_reg;
        insuf_next  = insuf_reg;
        prefix_next = prefix_reg;
        suffix_next = suffix_reg;
        sbl_next    = sbl_reg;
        explen_next = explen_reg;
        src_next    = src_reg;
        left_next   = left_reg;
        status_next = status_reg;
        resn_next   = resn_reg;
        emit_req    = 1'b0;
        emit_byte   = dict_rdata;
        bit_in      = shift_reg[7];
        suf_new     = {suffix_reg[19:0], bit_in};
        value       = prefix_reg + {1'b0, suf_new};
        back_dist   = value - 22'd256;
        n1          = sbl_reg + 5'd1;
        dict_raddr  = value[7:0];

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    resn_next = 5'd0;
                    state_next = S_OUT;
                    unique case (s_tuser)
                        lzgd_pkg::OP_LOAD: begin
                            state_next = S_OUT;
                        end
                        lzgd_pkg::OP_BYTE: begin
                            if (want) begin
                                shift_next = in_data;
                                bits_next  = 4'd8;
                                state_next = S_PARSE;
                            end
                        end
                        lzgd_pkg::OP_DRAIN: begin
                            if (status_reg == lzgd_pkg::ST_RUN) begin
                                state_next = (left_reg != 23'd0) ? S_CPRD : S_PARSE;
                            end
                        end
                        lzgd_pkg::OP_START: begin
                            wc_next     = 24'd0;
                            shift_next  = 8'd0;
                            bits_next   = 4'd0;
                            insuf_next  = 1'b0;
                            prefix_next = 22'd0;
                            suffix_next = 21'd0;
                            sbl_next    = 5'd0;
                            explen_next = 1'b0;
                            src_next    = 16'd0;
                            left_next   = 23'd0;
                            status_next = lzgd_pkg::ST_RUN;
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_PARSE: begin
                if (status_reg != lzgd_pkg::ST_RUN || left_reg != 23'd0
                        || bits_reg == 4'd0) begin
                    state_next = S_OUT;
                end else begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bits_next  = bits_reg - 4'd1;
                    if (!insuf_reg) begin
                        if (bit_in) begin
                            sbl_next = n1;
                            if (n1 > 5'(lzgd_pkg::MAX_PREFIX)) begin
                                status_next = lzgd_pkg::ST_TOO_LONG;
                            end
                        end else begin
                            prefix_next = 22'((23'd1 << n1) - 23'd2);
                            sbl_next    = n1;
                            suffix_next = 21'd0;
                            insuf_next  = 1'b1;
                        end
                    end else begin
                        suffix_next = suf_new;
                        sbl_next    = sbl_reg - 5'd1;
                        if (sbl_reg == 5'd1) begin
                            insuf_next = 1'b0;
                            if (explen_reg) begin
                                left_next   = {1'b0, value} + 23'd3;
                                explen_next = 1'b0;
                            end else if (value == 22'd256) begin
                                status_next = lzgd_pkg::ST_CODE256;
                            end else if (value < 22'd256) begin
                                state_next = S_LIT;
                            end else if ({2'b00, back_dist} > wc_reg
                                    || {1'b0, back_dist} > lzgd_pkg::WINDOW_SIZE) begin
                                status_next = lzgd_pkg::ST_BAD_DIST;
                            end else begin
                                src_next    = 16'(wc_reg - {2'b00, back_dist});
                                explen_next = 1'b1;
                            end
                        end
                    end
                end
            end
            S_LIT: begin
                emit_req   = 1'b1;
                emit_byte  = dict_rdata;
                state_next = S_PARSE;
            end
            S_CPRD: begin
                if (resn_reg == 5'(lzgd_pkg::RES_DEPTH) || left_reg == 23'd0
                        || status_reg != lzgd_pkg::ST_RUN) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_CPWR;
                end
            end
            S_CPWR: begin
                emit_req   = 1'b1;
                emit_byte  = hist_rdata;
                state_next = S_CPRD;
            end
            S_OUT: begin
                if (buf_done) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // byte emission into history and result buffer
        hist_we = 1'b0;
        if (emit_req) begin
            if (wc_reg >= limit_reg || resn_reg >= 5'(lzgd_pkg::RES_DEPTH)) begin
                status_next = lzgd_pkg::ST_LIMIT;
            end else begin
                hist_we   = 1'b1;
                wc_next   = wc_reg + 24'd1;
                resn_next = resn_reg + 5'd1;
                if (state_reg == S_CPWR) begin
                    src_next  = src_reg + 16'd1;
                    left_next = left_reg - 23'd1;
                end
            end
        end
    end

    // result buffer interface
    always_comb begin
        push.en      = hist_we;
        push.idx     = resn_reg[lzgd_pkg::RES_AW-1:0];
        push.data    = emit_byte;
        push.count   = wc_reg + 24'd1;
        info.active  = (state_reg == S_OUT);
        info.res_n   = resn_reg;
        info.want    = want;
        info.status  = status_reg;
        info.count   = wc_reg;
    end

    lzgd_result_buf u_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .info     (info),
        .done     (buf_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            limit_reg  <= lzgd_pkg::OUT_LIMIT_RST;
            wc_reg     <= 24'd0;
            shift_reg  <= 8'd0;
            bits_reg   <= 4'd0;
            insuf_reg  <= 1'b0;
            prefix_reg <= 22'd0;
            suffix_reg <= 21'd0;
            sbl_reg    <= 5'd0;
            explen_reg <= 1'b0;
            src_reg    <= 16'd0;
            left_reg   <= 23'd0;
            status_reg <= lzgd_pkg::ST_RUN;
            resn_reg   <= 5'd0;
        end else begin
            state_reg  <= state_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            wc_reg     <= wc_next;
            shift_reg  <= shift_next;
            bits_reg   <= bits_next;
            insuf_reg  <= insuf_next;
            prefix_reg <= prefix_next;
            suffix_reg <= suffix_next;
            sbl_reg    <= sbl_next;
            explen_reg <= explen_next;
            src_reg    <= src_next;
            left_reg   <= left_next;
            status_reg <= status_next;
            resn_reg   <= resn_next;
        end
    end

endmodule
`default_nettype wire
